// ===== design/mi3_pkg.sv =====
// Shared widths, types and cofactor index tables for the 3x3 matrix inverse.
package mi3_pkg;

	localparam int EL_W   = 16;  // Q8.8 element
	localparam int PR_W   = 32;  // element product
	localparam int COF_W  = 33;  // signed cofactor
	localparam int CABS_W = 32;  // cofactor magnitude
	localparam int DET_W  = 49;  // signed determinant
	localparam int DABS_W = 48;  // determinant magnitude
	localparam int FRAC_W = 24;  // numerator shift
	localparam int Q_W    = 33;  // quotient bits produced by the divider
	localparam int OUT_W  = 32;  // Q16.16 result
	localparam int N_EL   = 9;
	localparam int IDX_W  = 4;
	localparam int DIV_STAGES = Q_W;

	typedef logic [IDX_W-1:0] idx_t;

	// cofactor k = a*b - c*d, negated for odd k; element index = col*3 + row
	localparam idx_t COF_A [N_EL] = '{4'd4, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0};
	localparam idx_t COF_B [N_EL] = '{4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd5, 4'd7, 4'd7, 4'd4};
	localparam idx_t COF_C [N_EL] = '{4'd7, 4'd7, 4'd4, 4'd6, 4'd6, 4'd3, 4'd6, 4'd6, 4'd3};
	localparam idx_t COF_D [N_EL] = '{4'd5, 4'd2, 4'd2, 4'd5, 4'd2, 4'd2, 4'd4, 4'd1, 4'd1};

	localparam idx_t LAST_IDX = idx_t'(N_EL - 1);

	typedef struct packed {
		logic vld;
		idx_t idx;
		logic neg;
		logic ovf;
		logic sing;
	} dctl_t;

endpackage

// ===== design/matrix3_inverse_top.sv =====
// Top level of the 3x3 fixed-point matrix inverse by the adjugate method.
//
// One matrix is taken per start beat while busy is low; busy then stays high
// while its down-counter runs, and a new matrix can be taken as soon as it falls,
// while earlier ones are still in the pipeline. The start spacing is matched to
// the single pipelined divider, which takes one of the nine cofactor quotients
// per cycle. A result appears as a one-cycle done strobe with all nine Q16.16
// elements and the singular flag; the receiver cannot stall, so results must be captured in that cycle.
module matrix3_inverse_top
	import mi3_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [EL_W-1:0]  in_c0_r0,
	input  logic signed [EL_W-1:0]  in_c0_r1,
	input  logic signed [EL_W-1:0]  in_c0_r2,
	input  logic signed [EL_W-1:0]  in_c1_r0,
	input  logic signed [EL_W-1:0]  in_c1_r1,
	input  logic signed [EL_W-1:0]  in_c1_r2,
	input  logic signed [EL_W-1:0]  in_c2_r0,
	input  logic signed [EL_W-1:0]  in_c2_r1,
	input  logic signed [EL_W-1:0]  in_c2_r2,
	output logic                    done,
	output logic signed [OUT_W-1:0] out_c0_r0,
	output logic signed [OUT_W-1:0] out_c0_r1,
	output logic signed [OUT_W-1:0] out_c0_r2,
	output logic signed [OUT_W-1:0] out_c1_r0,
	output logic signed [OUT_W-1:0] out_c1_r1,
	output logic signed [OUT_W-1:0] out_c1_r2,
	output logic signed [OUT_W-1:0] out_c2_r0,
	output logic signed [OUT_W-1:0] out_c2_r1,
	output logic signed [OUT_W-1:0] out_c2_r2,
	output logic                    singular
);

	logic       accept;
	logic [3:0] bcnt_q;

	assign accept = start && !busy;
	assign busy   = (bcnt_q != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= 4'd0;
		end else if (accept) begin
			bcnt_q <= 4'(N_EL - 1);
		end else if (bcnt_q != 4'd0) begin
			bcnt_q <= bcnt_q - 4'd1;
		end
	end

	// Stage 1: capture the matrix.
	logic                   v_s1;
	logic signed [EL_W-1:0] m_s1 [N_EL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_s1[0] <= in_c0_r0;
			m_s1[1] <= in_c0_r1;
			m_s1[2] <= in_c0_r2;
			m_s1[3] <= in_c1_r0;
			m_s1[4] <= in_c1_r1;
			m_s1[5] <= in_c1_r2;
			m_s1[6] <= in_c2_r0;
			m_s1[7] <= in_c2_r1;
			m_s1[8] <= in_c2_r2;
		end
	end

	// Stage 2: the eighteen element products.
	logic                   v_s2;
	logic signed [PR_W-1:0] pab_s2 [N_EL];
	logic signed [PR_W-1:0] pcd_s2 [N_EL];
	logic signed [EL_W-1:0] r0_s2 [3];

	// Stage 3: cofactors.
	logic                    v_s3;
	logic signed [COF_W-1:0] cof_s3 [N_EL];
	logic signed [EL_W-1:0]  r0_s3 [3];

	// Stage 4: first-row terms of the determinant.
	logic                    v_s4;
	logic signed [COF_W-1:0] cof_s4 [N_EL];
	logic signed [DET_W-1:0] dp_s4 [3];

	// Stage 5: determinant.
	logic                    v_s5;
	logic signed [COF_W-1:0] cof_s5 [N_EL];
	logic signed [DET_W-1:0] det_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_EL; k++) begin
			pab_s2[k] <= PR_W'(m_s1[COF_A[k]] * m_s1[COF_B[k]]);
			pcd_s2[k] <= PR_W'(m_s1[COF_C[k]] * m_s1[COF_D[k]]);
			if (k % 2 == 1) begin
				cof_s3[k] <= COF_W'(pcd_s2[k]) - COF_W'(pab_s2[k]);
			end else begin
				cof_s3[k] <= COF_W'(pab_s2[k]) - COF_W'(pcd_s2[k]);
			end
			cof_s4[k] <= cof_s3[k];
			cof_s5[k] <= cof_s4[k];
		end
		for (int j = 0; j < 3; j++) begin
			r0_s2[j] <= m_s1[3*j];
			r0_s3[j] <= r0_s2[j];
			dp_s4[j] <= DET_W'(DET_W'(r0_s3[j]) * DET_W'(cof_s3[j]));
		end
		det_s5 <= dp_s4[0] + dp_s4[1] + dp_s4[2];
	end

	// Issue sequencer: hands the nine cofactors to the divider, one per cycle.
	logic                     act_q;
	idx_t                     fcnt_q;
	logic signed [COF_W-1:0]  hcof_q [N_EL];
	logic [DABS_W-1:0]        dabs_q;
	logic                     dneg_q;
	logic                     sing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			fcnt_q <= '0;
		end else if (v_s5) begin
			act_q  <= 1'b1;
			fcnt_q <= '0;
		end else if (act_q) begin
			act_q  <= (fcnt_q != LAST_IDX);
			if (fcnt_q != LAST_IDX) begin
				fcnt_q <= fcnt_q + idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s5) begin
			hcof_q <= cof_s5;
			dneg_q <= det_s5[DET_W-1];
			sing_q <= (det_s5 == '0);
			dabs_q <= det_s5[DET_W-1] ? DABS_W'(-det_s5) : DABS_W'(det_s5);
		end
	end

	logic signed [COF_W-1:0] icof;
	logic [CABS_W-1:0]       icabs;

	always_comb begin
		icof  = hcof_q[fcnt_q];
		icabs = icof[COF_W-1] ? CABS_W'(-icof) : CABS_W'(icof);
	end

	// Restoring divider, one quotient bit per stage.
	dctl_t             dctl [DIV_STAGES+1];
	logic [DABS_W-1:0] drem [DIV_STAGES+1];
	logic [DABS_W-1:0] dden [DIV_STAGES+1];
	logic [Q_W-1:0]    dlow [DIV_STAGES+1];
	logic [Q_W-1:0]    dquo [DIV_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dctl[0] <= '0;
		end else begin
			dctl[0].vld  <= act_q;
			dctl[0].idx  <= fcnt_q;
			dctl[0].neg  <= icof[COF_W-1] ^ dneg_q;
			dctl[0].ovf  <= (DABS_W'(icabs[CABS_W-1:Q_W-FRAC_W]) >= dabs_q);
			dctl[0].sing <= sing_q;
		end
	end

	always_ff @(posedge clk) begin
		drem[0] <= DABS_W'(icabs[CABS_W-1:Q_W-FRAC_W]);
		dlow[0] <= {icabs[Q_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
		dden[0] <= dabs_q;
		dquo[0] <= '0;
	end

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		logic [DABS_W:0] trial;
		logic            ge;

		always_comb begin
			trial = {drem[g], dlow[g][Q_W-1]};
			ge    = (trial >= {1'b0, dden[g]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dctl[g+1] <= '0;
			end else begin
				dctl[g+1] <= dctl[g];
			end
		end

		always_ff @(posedge clk) begin
			drem[g+1] <= ge ? DABS_W'(trial - {1'b0, dden[g]}) : DABS_W'(trial);
			dlow[g+1] <= {dlow[g][Q_W-2:0], 1'b0};
			dden[g+1] <= dden[g];
			dquo[g+1] <= {dquo[g][Q_W-2:0], ge};
		end
	end

	// Sign, saturation, singular zeroing and collection of the nine quotients.
	dctl_t                   fctl;
	logic [Q_W-1:0]          fq;
	logic signed [OUT_W-1:0] fval;

	always_comb begin
		fctl = dctl[DIV_STAGES];
		fq   = dquo[DIV_STAGES];
		if (fctl.sing) begin
			fval = '0;
		end else if (fctl.neg) begin
			if (fctl.ovf || fq > {1'b0, 1'b1, {(OUT_W-1){1'b0}}}) begin
				fval = {1'b1, {(OUT_W-1){1'b0}}};
			end else begin
				fval = -$signed(fq[OUT_W-1:0]);
			end
		end else begin
			if (fctl.ovf || fq[Q_W-1] || fq[OUT_W-1]) begin
				fval = {1'b0, {(OUT_W-1){1'b1}}};
			end else begin
				fval = $signed(fq[OUT_W-1:0]);
			end
		end
	end

	logic signed [OUT_W-1:0] coll_q [N_EL-1];
	logic                    done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fctl.vld && (fctl.idx == LAST_IDX);
		end
	end

	always_ff @(posedge clk) begin
		if (fctl.vld) begin
			if (fctl.idx == LAST_IDX) begin
				out_c0_r0 <= coll_q[0];
				out_c0_r1 <= coll_q[1];
				out_c0_r2 <= coll_q[2];
				out_c1_r0 <= coll_q[3];
				out_c1_r1 <= coll_q[4];
				out_c1_r2 <= coll_q[5];
				out_c2_r0 <= coll_q[6];
				out_c2_r1 <= coll_q[7];
				out_c2_r2 <= fval;
				singular  <= fctl.sing;
			end else begin
				coll_q[fctl.idx[2:0]] <= fval;
			end
		end
	end

	assign done = done_q;

endmodule

// ===== design/mi3_checker.sv =====
// Port-level checker for the 3x3 matrix inverse, bound to the top level.
module mi3_checker
	import mi3_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic signed [OUT_W-1:0] out_c0_r0,
	input logic signed [OUT_W-1:0] out_c2_r2,
	input logic                    singular
);

	// A start beat taken while idle makes the block busy next cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted start");

	// Two result strobes never touch: done is never high in adjacent cycles.
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result beats in adjacent cycles");

	// A singular result carries zero elements (checked on out_c0_r0 and out_c2_r2).
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && singular |-> out_c0_r0 == '0 && out_c2_r2 == '0)
		else $error("singular result with nonzero elements");

	// busy only rises on a start beat.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start beat");

endmodule

bind matrix3_inverse_top mi3_checker u_mi3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.out_c0_r0 (out_c0_r0),
	.out_c2_r2 (out_c2_r2),
	.singular  (singular)
);
